/* rtl/ecnpv_pkg.sv */
`default_nettype none

package ecnpv_pkg;

  // field widths as they travel on the streams
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CNT_FIELD_W = 62;
  localparam int unsigned TIME_W     = 63;
  localparam int unsigned SENT_W     = 32;
  localparam int unsigned THR_W      = 32;

  // default for the count width parameter
  localparam int unsigned COUNT_WIDTH_DEF = 62;

  // threshold after reset
  localparam logic [THR_W-1:0] THR_RESET = 32'd10;

  // input tdata layout, lowest field first
  localparam int unsigned ECT0_LSB  = 0;
  localparam int unsigned ECT1_LSB  = ECT0_LSB + CNT_FIELD_W;
  localparam int unsigned CE_LSB    = ECT1_LSB + CNT_FIELD_W;
  localparam int unsigned ACKED_LSB = CE_LSB + CNT_FIELD_W;
  localparam int unsigned STIME_LSB = ACKED_LSB + CNT_FIELD_W;
  localparam int unsigned SENT_LSB  = STIME_LSB + TIME_W;
  localparam int unsigned S_BITS    = SENT_LSB + SENT_W;
  localparam int unsigned S_TDATA_W = ((S_BITS + 7) / 8) * 8;

  // output tdata layout: verdict, three flags, congestion time
  localparam int unsigned VERDICT_W = 2;
  localparam int unsigned M_BITS    = VERDICT_W + 3 + TIME_W;
  localparam int unsigned M_TDATA_W = ((M_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ACK     = 2'd0,
    OP_SENT    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_DISABLE = 2'd3
  } op_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_CONG = 2'd1,
    VERDICT_FAIL = 2'd2
  } verdict_t;

  // validation state of the path, one-hot
  typedef enum logic [2:0] {
    PATH_TESTING = 3'b001,
    PATH_CAPABLE = 3'b010,
    PATH_FAILED  = 3'b100
  } path_t;

  // control of the input register toward the execute stage
  typedef struct packed {
    logic valid;
    op_t  op;
  } stage_ctrl_t;

endpackage

`default_nettype wire

/* rtl/ecn_path_validation_core.sv */
`default_nettype none

// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  tuser operation, tdata counts, time, sent
// m_*       out  m_tvalid / m_tready  tdata verdict, flags, congestion time
// cfg_*     in   cfg_we               cfg_wdata validation threshold
//
// one item per cycle sustained while m_tready is high; an accepted item reaches
// m_* through the registers below
// (input register, then execute and result register)
// the path state is read and updated by the execute stage in the same cycle
// rst is synchronous; threshold returns to 10, path to testing, no clearing pass
// while m_tready is low the result holds and one more item waits in the
// input register; s_tready drops only when both are full

module ecn_path_validation_core #(
  parameter int unsigned COUNT_WIDTH = ecnpv_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // ect0 [61:0], ect1 [123:62], ce [185:124], acked_packets [247:186],
  // send_time [310:248], sent_packets [342:311]
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [ecnpv_pkg::S_TDATA_W-1:0]  s_tdata,
  // operation [1:0]
  input  wire logic [ecnpv_pkg::OP_W-1:0]       s_tuser,
  // verdict [1:0], path_capable [2], path_testing [3], path_failed [4],
  // congestion_time [67:5]
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [ecnpv_pkg::M_TDATA_W-1:0]       m_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [ecnpv_pkg::THR_W-1:0]      cfg_wdata
);

  ecnpv_pkg::stage_ctrl_t        ctrl;
  logic [COUNT_WIDTH-1:0]        st_ect0;
  logic [COUNT_WIDTH-1:0]        st_ect1;
  logic [COUNT_WIDTH-1:0]        st_ce;
  logic [COUNT_WIDTH+1:0]        st_total;
  logic [COUNT_WIDTH+2:0]        st_margin;
  logic [ecnpv_pkg::TIME_W-1:0]  st_time;
  logic                          st_sent_nz;
  logic                          adv;

  // input register with precomputed sums
  ecnpv_in_stage #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .adv        (adv),
    .ctrl       (ctrl),
    .st_ect0    (st_ect0),
    .st_ect1    (st_ect1),
    .st_ce      (st_ce),
    .st_total   (st_total),
    .st_margin  (st_margin),
    .st_time    (st_time),
    .st_sent_nz (st_sent_nz)
  );

  // path state, checks and result register
  ecnpv_exec #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .ctrl       (ctrl),
    .st_ect0    (st_ect0),
    .st_ect1    (st_ect1),
    .st_ce      (st_ce),
    .st_total   (st_total),
    .st_margin  (st_margin),
    .st_time    (st_time),
    .st_sent_nz (st_sent_nz),
    .adv        (adv),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // exactly one of capable, testing, failed in every result
  a_one_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tdata[4:2]))
    else $error("path flags not exclusive");

  // verdict code is one of the defined values
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ecnpv_pkg::VERDICT_NONE ||
                  m_tdata[1:0] == ecnpv_pkg::VERDICT_CONG ||
                  m_tdata[1:0] == ecnpv_pkg::VERDICT_FAIL))
    else $error("bad verdict code");

  // a failure verdict leaves the path failed
  a_fail_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == ecnpv_pkg::VERDICT_FAIL) |-> m_tdata[4])
    else $error("failure verdict without failed path");

  // congestion is only signaled on a path that has not failed
  a_cong_live: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == ecnpv_pkg::VERDICT_CONG) |-> !m_tdata[4])
    else $error("congestion on failed path");

endmodule

`default_nettype wire

/* rtl/ecnpv_in_stage.sv */
`default_nettype none

module ecnpv_in_stage #(
  parameter int unsigned COUNT_WIDTH = ecnpv_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [ecnpv_pkg::S_TDATA_W-1:0]     s_tdata,
  input  wire logic [ecnpv_pkg::OP_W-1:0]          s_tuser,
  input  wire logic                                adv,
  output ecnpv_pkg::stage_ctrl_t                   ctrl,
  output logic [COUNT_WIDTH-1:0]                   st_ect0,
  output logic [COUNT_WIDTH-1:0]                   st_ect1,
  output logic [COUNT_WIDTH-1:0]                   st_ce,
  output logic [COUNT_WIDTH+1:0]                   st_total,
  output logic [COUNT_WIDTH+2:0]                   st_margin,
  output logic [ecnpv_pkg::TIME_W-1:0]             st_time,
  output logic                                     st_sent_nz
);

  localparam int unsigned TOT_W = COUNT_WIDTH + 2;
  localparam int unsigned MRG_W = COUNT_WIDTH + 3;

  logic [COUNT_WIDTH-1:0] in_ect0;
  logic [COUNT_WIDTH-1:0] in_ect1;
  logic [COUNT_WIDTH-1:0] in_ce;
  logic [COUNT_WIDTH-1:0] in_acked;
  logic [TOT_W-1:0]       in_total;
  logic [MRG_W-1:0]       in_margin;
  logic                   load;

  // only the low count bits take part
  assign in_ect0  = s_tdata[ecnpv_pkg::ECT0_LSB +: COUNT_WIDTH];
  assign in_ect1  = s_tdata[ecnpv_pkg::ECT1_LSB +: COUNT_WIDTH];
  assign in_ce    = s_tdata[ecnpv_pkg::CE_LSB +: COUNT_WIDTH];
  assign in_acked = s_tdata[ecnpv_pkg::ACKED_LSB +: COUNT_WIDTH];

  // sum of the reported counts, and that sum less the acked packets
  assign in_total  = {2'b00, in_ect0} + {2'b00, in_ect1} + {2'b00, in_ce};
  assign in_margin = {1'b0, in_total} - {3'b000, in_acked};

  // register frees when the execute stage takes its item
  assign s_tready = !ctrl.valid || adv;
  assign load     = s_tvalid && s_tready;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
      ctrl.op    <= ecnpv_pkg::OP_ACK;
    end else if (load) begin
      ctrl.valid <= 1'b1;
      ctrl.op    <= ecnpv_pkg::op_t'(s_tuser);
    end else if (adv) begin
      ctrl.valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      st_ect0    <= in_ect0;
      st_ect1    <= in_ect1;
      st_ce      <= in_ce;
      st_total   <= in_total;
      st_margin  <= in_margin;
      st_time    <= s_tdata[ecnpv_pkg::STIME_LSB +: ecnpv_pkg::TIME_W];
      st_sent_nz <= |s_tdata[ecnpv_pkg::SENT_LSB +: ecnpv_pkg::SENT_W];
    end
  end

endmodule

`default_nettype wire

/* rtl/ecnpv_exec.sv */
`default_nettype none

module ecnpv_exec #(
  parameter int unsigned COUNT_WIDTH = ecnpv_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [ecnpv_pkg::THR_W-1:0]         cfg_wdata,
  input  wire ecnpv_pkg::stage_ctrl_t              ctrl,
  input  wire logic [COUNT_WIDTH-1:0]              st_ect0,
  input  wire logic [COUNT_WIDTH-1:0]              st_ect1,
  input  wire logic [COUNT_WIDTH-1:0]              st_ce,
  input  wire logic [COUNT_WIDTH+1:0]              st_total,
  input  wire logic [COUNT_WIDTH+2:0]              st_margin,
  input  wire logic [ecnpv_pkg::TIME_W-1:0]        st_time,
  input  wire logic                                st_sent_nz,
  output logic                                     adv,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [ecnpv_pkg::M_TDATA_W-1:0]          m_tdata
);

  localparam int unsigned TOT_W = COUNT_WIDTH + 2;
  localparam int unsigned CMP_W = (TOT_W > ecnpv_pkg::THR_W) ? TOT_W : ecnpv_pkg::THR_W;

  logic [ecnpv_pkg::THR_W-1:0] threshold;

  // path state
  ecnpv_pkg::path_t             path;
  ecnpv_pkg::path_t             path_next;
  logic [COUNT_WIDTH-1:0]       prev_ect0;
  logic [COUNT_WIDTH-1:0]       prev_ect0_next;
  logic [COUNT_WIDTH-1:0]       prev_ect1;
  logic [COUNT_WIDTH-1:0]       prev_ect1_next;
  logic [COUNT_WIDTH-1:0]       prev_ce;
  logic [COUNT_WIDTH-1:0]       prev_ce_next;
  logic [TOT_W-1:0]             prev_total;
  logic [TOT_W-1:0]             prev_total_next;
  logic                         sent_any;
  logic                         sent_any_next;
  logic [ecnpv_pkg::TIME_W-1:0] last_cong;
  logic [ecnpv_pkg::TIME_W-1:0] last_cong_next;

  // result register
  ecnpv_pkg::verdict_t          verdict_c;
  ecnpv_pkg::verdict_t          out_verdict;
  ecnpv_pkg::path_t             out_path;
  logic [ecnpv_pkg::TIME_W-1:0] out_time;

  logic fire;
  logic decrease;
  logic short_rise;
  logic reach;
  logic ce_rise;

  assign adv  = !m_tvalid || m_tready;
  assign fire = ctrl.valid && adv;

  // checks against the stored counts and the threshold
  assign decrease   = (st_ect0 < prev_ect0) || (st_ect1 < prev_ect1) || (st_ce < prev_ce);
  assign short_rise = st_margin[TOT_W] || (st_margin[TOT_W-1:0] < prev_total);
  assign reach      = CMP_W'(st_total) >= CMP_W'(threshold);
  assign ce_rise    = st_ce > prev_ce;

  // next state and verdict for the item in the execute stage
  always_comb begin
    path_next       = path;
    prev_ect0_next  = prev_ect0;
    prev_ect1_next  = prev_ect1;
    prev_ce_next    = prev_ce;
    prev_total_next = prev_total;
    sent_any_next   = sent_any;
    last_cong_next  = last_cong;
    verdict_c       = ecnpv_pkg::VERDICT_NONE;
    unique case (ctrl.op)
      ecnpv_pkg::OP_ACK: begin
        if (path == ecnpv_pkg::PATH_FAILED) begin
          verdict_c = ecnpv_pkg::VERDICT_FAIL;
        end else if (decrease) begin
          path_next = ecnpv_pkg::PATH_FAILED;
          verdict_c = ecnpv_pkg::VERDICT_FAIL;
        end else if (path == ecnpv_pkg::PATH_TESTING && short_rise && sent_any) begin
          path_next = ecnpv_pkg::PATH_FAILED;
          verdict_c = ecnpv_pkg::VERDICT_FAIL;
        end else begin
          if (path == ecnpv_pkg::PATH_TESTING && reach) begin
            path_next = ecnpv_pkg::PATH_CAPABLE;
          end
          if (ce_rise) begin
            verdict_c      = ecnpv_pkg::VERDICT_CONG;
            last_cong_next = st_time;
          end
          prev_ect0_next  = st_ect0;
          prev_ect1_next  = st_ect1;
          prev_ce_next    = st_ce;
          prev_total_next = st_total;
        end
      end
      ecnpv_pkg::OP_SENT: begin
        // the saturating sent total is only ever tested for nonzero
        if (path != ecnpv_pkg::PATH_FAILED) begin
          sent_any_next = sent_any || st_sent_nz;
        end
      end
      ecnpv_pkg::OP_CLEAR: begin
        path_next       = ecnpv_pkg::PATH_TESTING;
        prev_ect0_next  = '0;
        prev_ect1_next  = '0;
        prev_ce_next    = '0;
        prev_total_next = '0;
        sent_any_next   = 1'b0;
        last_cong_next  = '0;
      end
      ecnpv_pkg::OP_DISABLE: begin
        path_next = ecnpv_pkg::PATH_FAILED;
      end
      default: begin
      end
    endcase
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ecnpv_pkg::THR_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // path state update
  always_ff @(posedge clk) begin
    if (rst) begin
      path       <= ecnpv_pkg::PATH_TESTING;
      prev_ect0  <= '0;
      prev_ect1  <= '0;
      prev_ce    <= '0;
      prev_total <= '0;
      sent_any   <= 1'b0;
      last_cong  <= '0;
    end else if (fire) begin
      path       <= path_next;
      prev_ect0  <= prev_ect0_next;
      prev_ect1  <= prev_ect1_next;
      prev_ce    <= prev_ce_next;
      prev_total <= prev_total_next;
      sent_any   <= sent_any_next;
      last_cong  <= last_cong_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_verdict <= verdict_c;
      out_path    <= path_next;
      out_time    <= last_cong_next;
    end
  end

  assign m_tdata = {(ecnpv_pkg::M_TDATA_W - ecnpv_pkg::M_BITS)'(0),
                    out_time,
                    out_path == ecnpv_pkg::PATH_FAILED,
                    out_path == ecnpv_pkg::PATH_TESTING,
                    out_path == ecnpv_pkg::PATH_CAPABLE,
                    out_verdict};

endmodule

`default_nettype wire
